// ===== rtl/query_string_pair_parser_top_defines.svh =====
// Assertion macros for the query-string pair parser.
// Included by qsp_datapath for its concurrent checks; expects clock and reset in scope.
`ifndef QUERY_STRING_PAIR_PARSER_TOP_DEFINES_SVH
`define QUERY_STRING_PAIR_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define QSP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset
`define QSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/qsp_pkg.sv =====
// Shared types, constants and helper functions for the query-string pair parser.
// No dependencies; imported by the interfaces and all modules.
package qsp_pkg;

   localparam int SEG_DEPTH = 32;
   localparam int IDX_W     = $clog2(SEG_DEPTH);
   localparam int CNT_W     = $clog2(SEG_DEPTH + 1);
   localparam int EMIT_W    = CNT_W + 1;
   localparam int CHAR_W    = 8;

   localparam logic [CHAR_W-1:0] CH_EQ        = 8'h3d;
   localparam logic [CHAR_W-1:0] CH_AMP       = 8'h26;
   localparam logic [CHAR_W-1:0] CH_PCT       = 8'h25;
   localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0] HEX_CASE_MSK = 8'hdf;
   localparam logic [CHAR_W-1:0] HEX_LETTER   = 8'd10;

   // Controller to datapath
   typedef struct packed {
      logic              append;
      logic [CHAR_W-1:0] char_code;
      logic              dec_start;
      logic              dec_to_name;
      logic              emit_start;
      logic              term_clear;
      logic              end_reset;
   } qsp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic dec_done;
      logic emit_done;
      logic pair_ok;
   } qsp_status_type;

   // Loose hex digit value, modulo 256
   function automatic logic [CHAR_W-1:0] hex_nibble(input logic [CHAR_W-1:0] b);
      logic [CHAR_W-1:0] v;
      if (b >= CH_UPPER_A) begin
         v = (b & HEX_CASE_MSK) - CH_UPPER_A + HEX_LETTER;
      end else begin
         v = b - CH_ZERO;
      end
      return v;
   endfunction

endpackage

// ===== rtl/qsp_req_if.sv =====
// Request channel: one raw query-string character or an end marker per beat.
// Depends on qsp_pkg.
interface qsp_req_if import qsp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              is_end;

   modport source (output valid, char_code, is_end, input ready);
   modport sink   (input valid, char_code, is_end, output ready);
endinterface

// ===== rtl/qsp_rsp_if.sv =====
// Response channel: one decoded byte of an emitted pair per beat.
// Depends on qsp_pkg.
interface qsp_rsp_if import qsp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_byte;
   logic              part;
   logic              last;
   logic              truncated;

   modport source (output valid, out_byte, part, last, truncated, input ready);
   modport sink   (input valid, out_byte, part, last, truncated, output ready);
endinterface

// ===== rtl/qsp_datapath.sv =====
// Datapath: segment and name buffers, streaming percent decoder and pair emitter.
// Depends on qsp_pkg, qsp_rsp_if and the assertion macro header.
`include "query_string_pair_parser_top_defines.svh"

module qsp_datapath import qsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  qsp_cmd_type    cmd,
   output qsp_status_type status,
   qsp_rsp_if.source      rsp
);

   typedef enum logic [1:0] {PH_NORM, PH_HI, PH_LO} phase_type;

   logic [CHAR_W-1:0] raw_mem  [SEG_DEPTH];
   logic [CHAR_W-1:0] name_mem [SEG_DEPTH];

   logic [CNT_W-1:0]  raw_count_ff, name_count_ff;
   logic              pair_open_ff, overflow_ff;
   logic              dec_busy_ff, to_name_ff, dec_done_ff;
   logic [CNT_W-1:0]  src_idx_ff, dst_idx_ff;
   phase_type         phase_ff;
   logic [3:0]        hi_ff;
   logic              emit_busy_ff, emit_done_ff;
   logic [EMIT_W-1:0] emit_idx_ff;
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] out_byte_ff;
   logic              part_ff, last_ff, trunc_ff;

   logic [IDX_W-1:0]  rd_addr;
   logic [CHAR_W-1:0] rd_byte, name_byte, nib;
   logic [EMIT_W-1:0] val_off, emit_total;
   logic              in_name, emit_load, emit_last;
   logic              wr_en, dec_fin;
   logic [CHAR_W-1:0] wr_data;
   logic [CNT_W-1:0]  fin_len, src_in;
   phase_type         phase_in;
   logic [3:0]        hi_in;

   // Share the segment read port between decoder and emitter
   assign val_off    = emit_idx_ff - EMIT_W'(name_count_ff);
   assign rd_addr    = emit_busy_ff ? val_off[IDX_W-1:0] : src_idx_ff[IDX_W-1:0];
   assign rd_byte    = raw_mem[rd_addr];
   assign name_byte  = name_mem[emit_idx_ff[IDX_W-1:0]];
   assign nib        = hex_nibble(rd_byte);
   assign emit_total = EMIT_W'(name_count_ff) + EMIT_W'(raw_count_ff);
   assign in_name    = emit_idx_ff < EMIT_W'(name_count_ff);
   assign emit_last  = emit_idx_ff == emit_total - EMIT_W'(1);
   assign emit_load  = emit_busy_ff && (!rsp_valid_ff || rsp.ready);

   // One source byte per cycle through the decoder
   always_comb begin
      wr_en    = 1'b0;
      wr_data  = rd_byte;
      dec_fin  = 1'b0;
      fin_len  = dst_idx_ff;
      src_in   = src_idx_ff + CNT_W'(1);
      phase_in = phase_ff;
      hi_in    = hi_ff;
      if (src_idx_ff >= raw_count_ff) begin
         dec_fin = 1'b1;
      end else begin
         case (phase_ff)
            PH_NORM: begin
               if (rd_byte == CH_PCT) begin
                  if (raw_count_ff < CNT_W'(2)) begin
                     // lone percent decodes to zero
                     wr_en   = 1'b1;
                     wr_data = '0;
                     dec_fin = 1'b1;
                     fin_len = dst_idx_ff + CNT_W'(1);
                  end else if ((EMIT_W'(src_idx_ff) + EMIT_W'(2)) >=
                               EMIT_W'(raw_count_ff)) begin
                     // short escape ends the decode
                     dec_fin = 1'b1;
                  end else begin
                     phase_in = PH_HI;
                  end
               end else begin
                  wr_en = 1'b1;
               end
            end
            PH_HI: begin
               hi_in    = nib[3:0];
               phase_in = PH_LO;
            end
            PH_LO: begin
               wr_en    = 1'b1;
               wr_data  = {hi_ff, 4'h0} + nib;
               phase_in = PH_NORM;
            end
            default: begin
               dec_fin = 1'b1;
            end
         endcase
      end
   end

   // Buffer writes: append raw chars, decode in place or into the name store
   always_ff @(posedge clock) begin
      if (cmd.append && (raw_count_ff < CNT_W'(SEG_DEPTH))) begin
         raw_mem[raw_count_ff[IDX_W-1:0]] <= cmd.char_code;
      end else if (dec_busy_ff && wr_en && !to_name_ff) begin
         raw_mem[dst_idx_ff[IDX_W-1:0]] <= wr_data;
      end
      if (dec_busy_ff && wr_en && to_name_ff) begin
         name_mem[dst_idx_ff[IDX_W-1:0]] <= wr_data;
      end
   end

   // Control state: counts, flags, decoder and emitter sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_count_ff  <= '0;
         name_count_ff <= '0;
         pair_open_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
         dec_busy_ff   <= 1'b0;
         dec_done_ff   <= 1'b0;
         emit_busy_ff  <= 1'b0;
         emit_done_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dec_done_ff  <= 1'b0;
         emit_done_ff <= 1'b0;

         if (cmd.append) begin
            if (raw_count_ff < CNT_W'(SEG_DEPTH)) begin
               raw_count_ff <= raw_count_ff + CNT_W'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end

         if (cmd.dec_start) begin
            dec_busy_ff <= 1'b1;
            to_name_ff  <= cmd.dec_to_name;
            src_idx_ff  <= '0;
            dst_idx_ff  <= '0;
            phase_ff    <= PH_NORM;
         end else if (dec_busy_ff) begin
            if (dec_fin) begin
               dec_busy_ff <= 1'b0;
               dec_done_ff <= 1'b1;
               if (to_name_ff) begin
                  name_count_ff <= fin_len;
                  raw_count_ff  <= '0;
                  pair_open_ff  <= 1'b1;
               end else begin
                  raw_count_ff <= fin_len;
               end
            end else begin
               src_idx_ff <= src_in;
               phase_ff   <= phase_in;
               hi_ff      <= hi_in;
               if (wr_en) begin
                  dst_idx_ff <= dst_idx_ff + CNT_W'(1);
               end
            end
         end

         if (cmd.emit_start) begin
            emit_busy_ff <= 1'b1;
            emit_idx_ff  <= '0;
            pair_open_ff <= 1'b0;
         end else if (emit_load) begin
            emit_idx_ff <= emit_idx_ff + EMIT_W'(1);
            if (emit_last) begin
               emit_busy_ff <= 1'b0;
               emit_done_ff <= 1'b1;
            end
         end

         // Hold the beat until taken
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cmd.term_clear) begin
            raw_count_ff <= '0;
            overflow_ff  <= 1'b0;
            if (cmd.end_reset) begin
               name_count_ff <= '0;
               pair_open_ff  <= 1'b0;
            end
         end
      end
   end

   // Output beat payload
   always_ff @(posedge clock) begin
      if (emit_load) begin
         out_byte_ff <= in_name ? name_byte : rd_byte;
         part_ff     <= !in_name;
         last_ff     <= emit_last;
         trunc_ff    <= overflow_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_byte  = out_byte_ff;
   assign rsp.part      = part_ff;
   assign rsp.last      = last_ff;
   assign rsp.truncated = trunc_ff;

   assign status.dec_done  = dec_done_ff;
   assign status.emit_done = emit_done_ff;
   assign status.pair_ok   = pair_open_ff && (name_count_ff != '0);

   `QSP_ASSERT_SAME(a_busy_excl, dec_busy_ff, !emit_busy_ff, "decode and emit overlap")
   `QSP_ASSERT_SAME(a_raw_bound, 1'b1, raw_count_ff <= CNT_W'(SEG_DEPTH), "segment count overrun")
   `QSP_ASSERT_SAME(a_emit_name, emit_busy_ff, name_count_ff != '0, "emit with empty name")
   `QSP_ASSERT_NEXT(a_done_pulse, dec_done_ff, !dec_done_ff, "decode done not a single pulse")

endmodule

// ===== rtl/qsp_ctrl.sv =====
// Controller: accepts request beats and sequences decode passes and pair emission.
// Depends on qsp_pkg and qsp_req_if.
module qsp_ctrl import qsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   qsp_req_if.sink        req,
   input  qsp_status_type status,
   output qsp_cmd_type    cmd
);

   typedef enum logic [2:0] {ST_IDLE, ST_NAME, ST_VAL1, ST_VAL2, ST_EMIT} state_type;

   state_type state_ff, state_in;
   logic      end_ff, end_in;

   assign req.ready = (state_ff == ST_IDLE);

   // Decode the accepted beat and step through the passes
   always_comb begin
      state_in        = state_ff;
      end_in          = end_ff;
      cmd             = '0;
      cmd.char_code   = req.char_code;
      cmd.end_reset   = end_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.is_end || (req.char_code == CH_AMP)) begin
                  cmd.dec_start = 1'b1;
                  end_in        = req.is_end;
                  state_in      = ST_VAL1;
               end else if (req.char_code == CH_EQ) begin
                  cmd.dec_start   = 1'b1;
                  cmd.dec_to_name = 1'b1;
                  state_in        = ST_NAME;
               end else begin
                  cmd.append = 1'b1;
               end
            end
         end
         ST_NAME: begin
            if (status.dec_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_VAL1: begin
            if (status.dec_done) begin
               cmd.dec_start = 1'b1;
               state_in      = ST_VAL2;
            end
         end
         ST_VAL2: begin
            if (status.dec_done) begin
               if (status.pair_ok) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  cmd.term_clear = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (status.emit_done) begin
               cmd.term_clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the end-of-string flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
      end
   end

endmodule

// ===== rtl/query_string_pair_parser_top.sv =====
// Top level of the query-string pair parser: controller plus datapath.
// Depends on qsp_pkg, qsp_req_if, qsp_rsp_if, qsp_ctrl and qsp_datapath.
//
// Takes one query-string character per request beat; a plain character is
// appended to the segment buffer. An '=' percent-decodes the buffered
// segment (up to 32 characters) into the name, one source byte a cycle
// through the single decoder and the segment buffer's one read port. An '&'
// or end beat runs that decoder twice over the segment and then, if a name
// is stored and '=' was seen, sends the name bytes and value bytes at one
// beat per cycle while the receiver takes them, through a registered output
// stage. After the last beat is loaded, the emit done flag and then the
// controller state are registered before the next request is taken, even
// while that beat waits to be taken.
module query_string_pair_parser_top import qsp_pkg::*; (
   input logic       clock,
   input logic       reset,
   qsp_req_if.sink   req_chan,
   qsp_rsp_if.source rsp_chan
);

   qsp_cmd_type    cmd;
   qsp_status_type status;

   qsp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .status (status),
      .cmd    (cmd)
   );

   qsp_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_chan)
   );

endmodule
